[src/dqps_pkg.sv]
// Shared types and constants of the dual-queue priority scheduler.
package dqps_pkg;
    localparam int LEVELS     = 8;
    localparam int TASK_SLOTS = 4096;
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int ID_W       = $clog2(TASK_SLOTS);
    localparam int CNT_W      = ID_W + 1;
    localparam int Q_W        = LVL_W + 1;
    localparam int INFO_W     = LVL_W + 3;

    typedef enum logic [2:0] {
        OP_REGISTER  = 3'd0,
        OP_REQ_WAIT  = 3'd1,
        OP_REQ_ACT   = 3'd2,
        OP_UNLINK    = 3'd3,
        OP_REMOVE    = 3'd4,
        OP_PICK      = 3'd5,
        OP_NOP6      = 3'd6,
        OP_NOP7      = 3'd7
    } t_op;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LVL  = 3'd1;
    localparam logic [2:0] ST_NOT_REG  = 3'd2;
    localparam logic [2:0] ST_ALREADY  = 3'd3;
    localparam logic [2:0] ST_NO_TASK  = 3'd4;

    typedef struct packed {
        logic [2:0]      opcode;
        logic [11:0]     task_id;
        logic [2:0]      level;
        logic            queue_sel;
    } t_in;

    typedef struct packed {
        logic [2:0]      status;
        logic [11:0]     picked_task;
        logic            picked_valid;
    } t_out;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             qsel;
        logic             linked;
        logic             registered;
    } t_info;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_INFO, S_PICK, S_UNL, S_UNL_R, S_UNL_W,
        S_INS, S_INS_R, S_INS_W, S_INS_F, S_DONE
    } t_state;
endpackage

[src/dual_queue_priority_scheduler.sv]
// Top level: sequencer over link and task-info memories, queue registers, level scan.
//  channel | signals                         | direction
//  input   | i_in_valid, o_in_stall, i_in_data  | in
//  output  | o_out_valid, i_out_stall, o_out_data | out
// One beat at a time: the length of a beat is set by the link memory read-modify-write
// steps of unlink and insert; pick scans the levels combinationally in place of the task
// info read.
// After reset a clearing pass over all TASK_SLOTS (4096) entries zeroes the task info
// memory; no beat is taken until it ends.
// A held result stalls completion of the next beat, not its acceptance.
module dual_queue_priority_scheduler
    import dqps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);
    t_state r_state, n_state;
    t_in    r_in;
    logic [ID_W-1:0]  r_t, r_tail, r_clr;
    logic [LVL_W-1:0] r_lv;
    logic             r_sel;
    t_out             r_res, n_res;
    logic             r_ov;
    logic [ID_W-1:0]  r_head [2*LEVELS];
    logic [CNT_W-1:0] r_cnt  [2*LEVELS];
    logic [LEVELS-1:0] r_act;

    logic            nx_we, pv_we, in_we, lk_re, in_re;
    logic [ID_W-1:0] nx_wa, pv_wa, in_wa, nx_wd, pv_wd, lk_ra, in_ra;
    logic [ID_W-1:0] nx_rd, pv_rd;
    t_info           in_wd, in_rd;
    logic [INFO_W-1:0] info_raw;

    dqps_ram #(.WIDTH(ID_W), .DEPTH(TASK_SLOTS)) u_next (
        .i_clk, .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_re(lk_re), .i_raddr(lk_ra), .o_rdata(nx_rd));
    dqps_ram #(.WIDTH(ID_W), .DEPTH(TASK_SLOTS)) u_prev (
        .i_clk, .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_re(lk_re), .i_raddr(lk_ra), .o_rdata(pv_rd));
    dqps_ram #(.WIDTH(INFO_W), .DEPTH(TASK_SLOTS)) u_info (
        .i_clk, .i_we(in_we), .i_waddr(in_wa), .i_wdata(INFO_W'(in_wd)),
        .i_re(in_re), .i_raddr(in_ra), .o_rdata(info_raw));
    assign in_rd = t_info'(info_raw);

    logic [Q_W-1:0] q;
    logic           accept, done;
    assign q      = {r_lv, r_sel};
    assign accept = i_in_valid && !o_in_stall;
    assign done   = (r_state == S_DONE) && (!r_ov || !i_out_stall);

    // level scan
    logic              got1, got2;
    logic [LVL_W-1:0]  lv1, lv2;
    logic [LEVELS-1:0] swap;
    always_comb begin
        got1 = 1'b0; got2 = 1'b0; lv1 = '0; lv2 = '0; swap = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (!got1) begin
                if (r_cnt[{LVL_W'(l), r_act[l]}] != '0) begin
                    got1 = 1'b1;
                    lv1  = LVL_W'(l);
                end else begin
                    swap[l] = 1'b1;
                end
            end
        end
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (!got2 && r_cnt[{LVL_W'(l), ~r_act[l]}] != '0) begin
                got2 = 1'b1;
                lv2  = LVL_W'(l);
            end
        end
    end

    logic unl_single, is_req;
    assign unl_single = r_cnt[q] <= CNT_W'(1);
    assign is_req = (r_in.opcode == OP_REQ_WAIT) || (r_in.opcode == OP_REQ_ACT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == ID_W'(TASK_SLOTS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.opcode == OP_PICK) n_state = S_PICK;
                    else if (i_in_data.opcode <= OP_REMOVE) n_state = S_INFO;
                    else n_state = S_DONE;
                end
            end
            S_INFO: begin
                if (r_in.opcode == OP_REGISTER) begin
                    if (32'(r_in.level) >= LEVELS || in_rd.registered) n_state = S_DONE;
                    else n_state = S_INS;
                end else if (!in_rd.registered) n_state = S_DONE;
                else if (in_rd.linked) n_state = S_UNL;
                else n_state = S_UNL_W;
            end
            S_PICK:  n_state = (got1 || got2) ? S_UNL : S_DONE;
            S_UNL:   n_state = unl_single ? S_UNL_W : S_UNL_R;
            S_UNL_R: n_state = S_UNL_W;
            S_UNL_W: n_state = is_req ? S_INS : S_DONE;
            S_INS:   n_state = (r_cnt[q] == '0) ? S_INS_F : S_INS_R;
            S_INS_R: n_state = S_INS_W;
            S_INS_W: n_state = S_INS_F;
            S_INS_F: n_state = S_DONE;
            S_DONE:  if (done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        nx_we = 1'b0; pv_we = 1'b0; in_we = 1'b0; lk_re = 1'b0; in_re = 1'b0;
        nx_wa = r_t; pv_wa = r_t; in_wa = r_t; nx_wd = r_t; pv_wd = r_t;
        lk_ra = r_t; in_ra = i_in_data.task_id;
        in_wd = '{level: r_lv, qsel: 1'b0, linked: 1'b0, registered: 1'b1};
        unique case (r_state)
            S_CLEAR: begin
                in_we = 1'b1; in_wa = r_clr; in_wd = '0;
            end
            S_IDLE: in_re = accept;
            S_UNL:  lk_re = !unl_single;
            S_UNL_R: begin
                nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
                pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
            end
            S_UNL_W: begin
                in_we = 1'b1;
                if (r_in.opcode == OP_REMOVE) in_wd = '0;
            end
            S_INS: begin
                if (r_cnt[q] == '0) begin
                    nx_we = 1'b1; pv_we = 1'b1;
                end else begin
                    lk_re = 1'b1; lk_ra = r_head[q];
                end
            end
            S_INS_R: begin
                nx_we = 1'b1; nx_wd = r_head[q];
                pv_we = 1'b1; pv_wd = pv_rd;
            end
            S_INS_W: begin
                nx_we = 1'b1; nx_wa = r_tail;
                pv_we = 1'b1; pv_wa = r_head[q];
            end
            S_INS_F: begin
                in_we = 1'b1;
                in_wd = '{level: r_lv, qsel: r_sel, linked: 1'b1, registered: 1'b1};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_res = r_res;
        unique case (r_state)
            S_IDLE: n_res = '{status: ST_OK, picked_task: '0, picked_valid: 1'b0};
            S_INFO: begin
                if (r_in.opcode == OP_REGISTER) begin
                    if (32'(r_in.level) >= LEVELS) n_res.status = ST_BAD_LVL;
                    else if (in_rd.registered) n_res.status = ST_ALREADY;
                end else if (!in_rd.registered) n_res.status = ST_NOT_REG;
            end
            S_PICK: if (!(got1 || got2)) n_res.status = ST_NO_TASK;
            S_UNL_W: if (!is_req) n_res = '{status: ST_OK, picked_task: r_t,
                                            picked_valid: 1'b1};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_act   <= '0;
            for (int i = 0; i < 2 * LEVELS; i++) r_cnt[i] <= '0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            if (r_state == S_CLEAR) r_clr <= r_clr + ID_W'(1);
            if (done) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
            if (done) o_out_data <= r_res;
            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_in <= i_in_data;
                    r_t  <= i_in_data.task_id;
                end
                S_INFO: begin
                    if (r_in.opcode == OP_REGISTER) begin
                        r_lv  <= r_in.level;
                        r_sel <= r_in.queue_sel;
                    end else begin
                        r_lv  <= in_rd.level;
                        r_sel <= in_rd.qsel;
                    end
                end
                S_PICK: begin
                    r_act <= r_act ^ swap;
                    if (got1) begin
                        r_lv <= lv1; r_sel <= r_act[lv1];
                        r_t  <= r_head[{lv1, r_act[lv1]}];
                    end else begin
                        r_lv <= lv2; r_sel <= ~r_act[lv2];
                        r_t  <= r_head[{lv2, ~r_act[lv2]}];
                    end
                end
                S_UNL: if (unl_single) r_cnt[q] <= '0;
                S_UNL_R: begin
                    r_cnt[q] <= r_cnt[q] - CNT_W'(1);
                    if (r_head[q] == r_t) r_head[q] <= nx_rd;
                end
                S_UNL_W: r_sel <= r_act[r_lv] ^ (r_in.opcode == OP_REQ_WAIT);
                S_INS_R: r_tail <= pv_rd;
                S_INS_F: begin
                    r_head[q] <= r_t;
                    r_cnt[q]  <= r_cnt[q] + CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;

`ifndef SYNTHESIS
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.picked_valid |-> o_out_data.picked_task == '0)
        else $error("picked_task nonzero without picked_valid");
    a_notask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_NO_TASK |-> !o_out_data.picked_valid)
        else $error("idle pick reported a task");
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> o_in_stall && !o_out_valid)
        else $error("activity during clearing pass");
`endif
endmodule

[src/dqps_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module dqps_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
